### rtl/ile_pkg.sv
package ile_pkg;

	localparam int DEF_LIST_DEPTH = 16;
	localparam int DATA_W = 32;
	localparam int POS_W = 8;
	localparam int MODE_W = 2;
	localparam int STATUS_W = 3;
	localparam int LEN_W = 5;

	typedef enum logic [MODE_W-1:0] {
		MODE_PUSH = 2'd0,
		MODE_INSERT = 2'd1,
		MODE_DELETE = 2'd2,
		MODE_GET = 2'd3
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK = 3'd0,
		ST_FULL = 3'd1,
		ST_EMPTY = 3'd2,
		ST_RANGE = 3'd3,
		ST_HEAD = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_MOVE_RD,
		S_MOVE_WR,
		S_FINAL_WR,
		S_GET_WAIT,
		S_DONE
	} state_t;

	// one access per cycle on the element store
	typedef struct packed {
		logic wr;
		logic rd;
	} mem_cmd_t;

endpackage

### rtl/ile_mem.sv
module ile_mem #(
	parameter int DEPTH = ile_pkg::DEF_LIST_DEPTH,
	parameter int AW = $clog2(DEPTH)
) (
	input  logic                      clk,
	input  ile_pkg::mem_cmd_t         cmd,
	input  logic [AW-1:0]             addr,
	input  logic [ile_pkg::DATA_W-1:0] wdata,
	output logic [ile_pkg::DATA_W-1:0] rdata_q
);

	logic [ile_pkg::DATA_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			mem_q[addr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rdata_q <= mem_q[addr];
		end
	end

endmodule

### rtl/ile_ctrl.sv
module ile_ctrl #(
	parameter int DEPTH = ile_pkg::DEF_LIST_DEPTH,
	parameter int AW = $clog2(DEPTH),
	parameter int CW = $clog2(DEPTH + 1)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [ile_pkg::MODE_W-1:0]  mode,
	input  logic [ile_pkg::POS_W-1:0]   position,
	input  logic [ile_pkg::DATA_W-1:0]  item_value,
	output logic                       busy,
	output logic                       done,
	output logic [ile_pkg::DATA_W-1:0]  rd_value,
	output ile_pkg::status_t           st_value,
	output logic [CW-1:0]              count,
	output ile_pkg::mem_cmd_t          mem_cmd,
	output logic [AW-1:0]              mem_addr,
	output logic [ile_pkg::DATA_W-1:0]  mem_wdata,
	input  logic [ile_pkg::DATA_W-1:0]  mem_rdata
);

	localparam int XW = CW + ile_pkg::POS_W;

	ile_pkg::state_t state_q, state_d;
	ile_pkg::mode_t mode_q;
	logic [ile_pkg::POS_W-1:0] pos_q;
	logic [ile_pkg::DATA_W-1:0] val_q;
	logic [CW-1:0] n_q, n_d, n_inc, n_dec;
	logic [AW-1:0] k_q, k_d, k_adj, at_q, at_d, at_sel;
	logic [ile_pkg::DATA_W-1:0] rd_q, rd_d;
	ile_pkg::status_t st_q, st_d;
	logic [XW-1:0] n_x, pos_x, k_adj_x;

	assign n_inc = n_q + CW'(1);
	assign n_dec = n_q - CW'(1);
	assign n_x = XW'(n_q);
	assign pos_x = XW'(pos_q);
	// shared index unit: steps down for insert, up for delete
	assign k_adj = (mode_q == ile_pkg::MODE_INSERT) ? (k_q - AW'(1)) : (k_q + AW'(1));
	assign k_adj_x = XW'(k_adj);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ile_pkg::S_IDLE;
			n_q <= '0;
		end else begin
			state_q <= state_d;
			n_q <= n_d;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ile_pkg::S_IDLE && start) begin
			mode_q <= ile_pkg::mode_t'(mode);
			pos_q <= position;
			val_q <= item_value;
		end
		k_q <= k_d;
		at_q <= at_d;
		rd_q <= rd_d;
		st_q <= st_d;
	end

	always_comb begin
		state_d = state_q;
		n_d = n_q;
		k_d = k_q;
		at_d = at_q;
		rd_d = rd_q;
		st_d = st_q;
		mem_cmd = '0;
		mem_addr = '0;
		mem_wdata = val_q;
		at_sel = (pos_q == '0 || pos_x > n_x) ? n_q[AW-1:0] : pos_q[AW-1:0];
		case (state_q)
			ile_pkg::S_IDLE: begin
				if (start) begin
					state_d = ile_pkg::S_DECODE;
				end
			end
			ile_pkg::S_DECODE: begin
				rd_d = '0;
				st_d = ile_pkg::ST_OK;
				state_d = ile_pkg::S_DONE;
				case (mode_q)
					ile_pkg::MODE_PUSH: begin
						if (n_x >= XW'(DEPTH)) begin
							st_d = ile_pkg::ST_FULL;
						end else begin
							mem_cmd.wr = 1'b1;
							mem_addr = n_q[AW-1:0];
							n_d = n_inc;
						end
					end
					ile_pkg::MODE_INSERT: begin
						if (n_q == '0) begin
							st_d = ile_pkg::ST_EMPTY;
						end else if (n_x >= XW'(DEPTH)) begin
							st_d = ile_pkg::ST_FULL;
						end else begin
							at_d = at_sel;
							k_d = n_q[AW-1:0];
							if (at_sel == n_q[AW-1:0]) begin
								mem_cmd.wr = 1'b1;
								mem_addr = at_sel;
								n_d = n_inc;
							end else begin
								state_d = ile_pkg::S_MOVE_RD;
							end
						end
					end
					ile_pkg::MODE_DELETE: begin
						if (pos_q == '0) begin
							st_d = ile_pkg::ST_HEAD;
						end else if (n_q == '0) begin
							st_d = ile_pkg::ST_EMPTY;
						end else if (pos_x >= n_x) begin
							st_d = ile_pkg::ST_RANGE;
						end else begin
							k_d = pos_q[AW-1:0];
							if (pos_x + XW'(1) < n_x) begin
								state_d = ile_pkg::S_MOVE_RD;
							end else begin
								n_d = n_dec;
							end
						end
					end
					ile_pkg::MODE_GET: begin
						if (n_q == '0) begin
							st_d = ile_pkg::ST_EMPTY;
						end else begin
							mem_cmd.rd = 1'b1;
							mem_addr = (pos_x >= n_x) ? n_dec[AW-1:0] : pos_q[AW-1:0];
							state_d = ile_pkg::S_GET_WAIT;
						end
					end
					default: begin
						st_d = ile_pkg::ST_OK;
					end
				endcase
			end
			ile_pkg::S_MOVE_RD: begin
				mem_cmd.rd = 1'b1;
				mem_addr = k_adj;
				state_d = ile_pkg::S_MOVE_WR;
			end
			ile_pkg::S_MOVE_WR: begin
				mem_cmd.wr = 1'b1;
				mem_addr = k_q;
				mem_wdata = mem_rdata;
				k_d = k_adj;
				if (mode_q == ile_pkg::MODE_INSERT) begin
					state_d = (k_adj == at_q) ? ile_pkg::S_FINAL_WR : ile_pkg::S_MOVE_RD;
				end else if (k_adj_x + XW'(1) < n_x) begin
					state_d = ile_pkg::S_MOVE_RD;
				end else begin
					n_d = n_dec;
					state_d = ile_pkg::S_DONE;
				end
			end
			ile_pkg::S_FINAL_WR: begin
				mem_cmd.wr = 1'b1;
				mem_addr = at_q;
				n_d = n_inc;
				state_d = ile_pkg::S_DONE;
			end
			ile_pkg::S_GET_WAIT: begin
				rd_d = mem_rdata;
				state_d = ile_pkg::S_DONE;
			end
			ile_pkg::S_DONE: begin
				state_d = ile_pkg::S_IDLE;
			end
			default: begin
				state_d = ile_pkg::S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ile_pkg::S_IDLE);
	assign done = (state_q == ile_pkg::S_DONE);
	assign rd_value = rd_q;
	assign st_value = st_q;
	assign count = n_q;

endmodule

### rtl/indexed_list_engine.sv
// channel     | handshake              | payload
// ------------+------------------------+------------------------------------
// request     | start, busy            | mode, position, item_value
// result      | done (one-cycle pulse) | read_value, status, list_length
//
// a transaction is taken at an edge with start high and busy low; busy then
// stays high until the result has been shown for its single done cycle
// push, refused requests and appending inserts go from decode to done, get
// waits for the registered store read; an insert at 0 < p < length moves the
// elements from p up, a delete at p those above p down: each moved element
// costs one read and one write on the single store port
// arst_n clears the sequencer and the element count; store contents are not
// reset and are only read below the count
// the result side has no back pressure, so done is never stalled
module indexed_list_engine #(
	parameter int LIST_DEPTH = ile_pkg::DEF_LIST_DEPTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [ile_pkg::MODE_W-1:0]         mode,
	input  logic [ile_pkg::POS_W-1:0]          position,
	input  logic signed [ile_pkg::DATA_W-1:0]  item_value,
	output logic                              done,
	output logic signed [ile_pkg::DATA_W-1:0]  read_value,
	output logic [ile_pkg::STATUS_W-1:0]       status,
	output logic [ile_pkg::LEN_W-1:0]          list_length
);

	// address and count widths follow the list capacity
	localparam int AW = $clog2(LIST_DEPTH);
	localparam int CW = $clog2(LIST_DEPTH + 1);

	ile_pkg::mem_cmd_t mem_cmd;
	logic [AW-1:0] mem_addr;
	logic [ile_pkg::DATA_W-1:0] mem_wdata, mem_rdata;
	logic [ile_pkg::DATA_W-1:0] rd_value;
	ile_pkg::status_t st_value;
	logic [CW-1:0] count;

	// sequencer: decodes the request and walks the shift one element at a time
	ile_ctrl #(
		.DEPTH(LIST_DEPTH),
		.AW(AW),
		.CW(CW)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.mode(mode),
		.position(position),
		.item_value(item_value),
		.busy(busy),
		.done(done),
		.rd_value(rd_value),
		.st_value(st_value),
		.count(count),
		.mem_cmd(mem_cmd),
		.mem_addr(mem_addr),
		.mem_wdata(mem_wdata),
		.mem_rdata(mem_rdata)
	);

	// element store, one port, registered read
	ile_mem #(
		.DEPTH(LIST_DEPTH),
		.AW(AW)
	) u_mem (
		.clk(clk),
		.cmd(mem_cmd),
		.addr(mem_addr),
		.wdata(mem_wdata),
		.rdata_q(mem_rdata)
	);

	assign read_value = rd_value;
	assign status = st_value;
	// length is reported in its low bits
	assign list_length = ile_pkg::LEN_W'(count);

`ifndef SYNTHESIS
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after accepted transaction");

	a_done_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy && !done)
		else $error("sequencer did not return to idle after result");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count <= CW'(LIST_DEPTH))
		else $error("element count beyond capacity");

	a_no_store_access_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> !mem_cmd.wr && !mem_cmd.rd)
		else $error("store accessed while idle");
`endif

endmodule

### bench/indexed_list_engine_checker.sv
`timescale 1ns / 1ps

module indexed_list_engine_checker
	import ile_pkg::*;
#(
	parameter int LIST_DEPTH = DEF_LIST_DEPTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic                     busy,
	input  logic [MODE_W-1:0]        mode,
	input  logic [POS_W-1:0]         position,
	input  logic signed [DATA_W-1:0] item_value,
	input  logic                     done,
	input  logic signed [DATA_W-1:0] read_value,
	input  logic [STATUS_W-1:0]      status,
	input  logic [LEN_W-1:0]         list_length,
	output int                       fail_count,
	output int                       pending_count
);

	typedef struct packed {
		logic signed [DATA_W-1:0] read_value;
		status_t                  status;
		logic [LEN_W-1:0]         list_length;
	} list_reply_t;

	// shadow copy of the list contents and length
	logic signed [DATA_W-1:0] shadow_list [LIST_DEPTH];
	int                       shadow_count;
	list_reply_t              predicted_replies [$];

	task automatic apply_list_request(
		input  logic [MODE_W-1:0]        req_mode,
		input  logic [POS_W-1:0]         req_pos,
		input  logic signed [DATA_W-1:0] req_val,
		output list_reply_t              reply
	);
		int n;
		int at;
		int k;
		n = shadow_count;
		reply.read_value = '0;
		reply.status = ST_OK;
		case (mode_t'(req_mode))
			MODE_PUSH: begin
				if (n >= LIST_DEPTH) begin
					reply.status = ST_FULL;
				end else begin
					shadow_list[n] = req_val;
					n++;
				end
			end
			MODE_INSERT: begin
				if (n == 0) begin
					reply.status = ST_EMPTY;
				end else if (n >= LIST_DEPTH) begin
					reply.status = ST_FULL;
				end else begin
					// zero or past the end appends
					at = (req_pos == 0 || int'(req_pos) > n) ? n : int'(req_pos);
					for (k = n; k > at; k--)
						shadow_list[k] = shadow_list[k-1];
					shadow_list[at] = req_val;
					n++;
				end
			end
			MODE_DELETE: begin
				if (req_pos == 0) begin
					reply.status = ST_HEAD;
				end else if (n == 0) begin
					reply.status = ST_EMPTY;
				end else if (int'(req_pos) >= n) begin
					reply.status = ST_RANGE;
				end else begin
					for (k = int'(req_pos); k + 1 < n; k++)
						shadow_list[k] = shadow_list[k+1];
					n--;
				end
			end
			default: begin
				if (n == 0) begin
					reply.status = ST_EMPTY;
				end else begin
					// past the end reads the last element
					at = (int'(req_pos) >= n) ? n - 1 : int'(req_pos);
					reply.read_value = shadow_list[at];
				end
			end
		endcase
		shadow_count = n;
		reply.list_length = n[LEN_W-1:0];
	endtask

	always @(posedge clk or negedge arst_n) begin
		list_reply_t fresh;
		list_reply_t oldest;
		if (!arst_n) begin
			shadow_count = 0;
			predicted_replies.delete();
			pending_count = 0;
			fail_count = 0;
		end else begin
			if (start && !busy) begin
				apply_list_request(mode, position, item_value, fresh);
				predicted_replies.push_back(fresh);
			end
			if (done) begin
				if (predicted_replies.size() == 0) begin
					$display("%0t result with nothing pending: read_value %0d status %0d length %0d",
						$time, read_value, status, list_length);
					fail_count++;
				end else begin
					oldest = predicted_replies.pop_front();
					if (read_value !== oldest.read_value) begin
						$display("%0t read_value expected %0d actual %0d",
							$time, oldest.read_value, read_value);
						fail_count++;
					end
					if (status !== oldest.status) begin
						$display("%0t status expected %0d actual %0d",
							$time, oldest.status, status);
						fail_count++;
					end
					if (list_length !== oldest.list_length) begin
						$display("%0t list_length expected %0d actual %0d",
							$time, oldest.list_length, list_length);
						fail_count++;
					end
				end
			end
			pending_count = predicted_replies.size();
		end
	end

endmodule

### bench/indexed_list_engine_test.sv
`timescale 1ns / 1ps

module indexed_list_engine_test;
	import ile_pkg::*;

	localparam int DEPTH = DEF_LIST_DEPTH;
	// longest transaction is an insert at position 1 of a nearly full list
	localparam int DRAIN_CYCLES = 4 + 2 * DEPTH + 8;
	localparam int RANDOM_PER_PHASE = 550;
	localparam int GAP_CAP = 24;

	logic                     clk;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	logic [MODE_W-1:0]        mode;
	logic [POS_W-1:0]         position;
	logic signed [DATA_W-1:0] item_value;
	logic                     done;
	logic signed [DATA_W-1:0] read_value;
	logic [STATUS_W-1:0]      status;
	logic [LEN_W-1:0]         list_length;

	int fail_count;
	int pending_count;
	int sent_count;
	int sender_idle_pct;
	// fill or drain bias of the random traffic
	logic fill_bias;
	int   bias_left;

	indexed_list_engine #(
		.LIST_DEPTH(DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.mode(mode),
		.position(position),
		.item_value(item_value),
		.done(done),
		.read_value(read_value),
		.status(status),
		.list_length(list_length)
	);

	indexed_list_engine_checker #(
		.LIST_DEPTH(DEPTH)
	) list_checker (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.mode(mode),
		.position(position),
		.item_value(item_value),
		.done(done),
		.read_value(read_value),
		.status(status),
		.list_length(list_length),
		.fail_count(fail_count),
		.pending_count(pending_count)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// one request transaction: optional idle gap, then hold start until taken
	task automatic send_request(
		input mode_t                    req_mode,
		input logic [POS_W-1:0]         req_pos,
		input logic signed [DATA_W-1:0] req_val
	);
		int gap;
		gap = 0;
		while (gap < GAP_CAP && $urandom_range(99) < sender_idle_pct)
			gap++;
		// start only drops when there really is an idle cycle
		repeat (gap) begin
			@(negedge clk);
			start = 1'b0;
		end
		@(negedge clk);
		start = 1'b1;
		mode = req_mode;
		position = req_pos;
		item_value = req_val;
		// busy only moves at a rising edge, so low here means taken at the next one
		while (busy)
			@(negedge clk);
		@(posedge clk);
		sent_count++;
	endtask

	// hold off new transactions until every predicted result has come back
	task automatic wait_for_quiet;
		@(negedge clk);
		start = 1'b0;
		while (pending_count != 0)
			@(negedge clk);
	endtask

	task automatic send_random_request;
		int                       pick;
		mode_t                    req_mode;
		logic [POS_W-1:0]         req_pos;
		logic signed [DATA_W-1:0] req_val;
		if (bias_left == 0) begin
			fill_bias = ~fill_bias;
			bias_left = $urandom_range(20, 60);
		end
		bias_left--;
		pick = $urandom_range(99);
		if (fill_bias) begin
			// growing phase: mostly push and insert so the list hits full
			if (pick < 40)
				req_mode = MODE_PUSH;
			else if (pick < 80)
				req_mode = MODE_INSERT;
			else if (pick < 93)
				req_mode = MODE_GET;
			else
				req_mode = MODE_DELETE;
		end else begin
			// shrinking phase: mostly deletes down toward a single element
			if (pick < 60)
				req_mode = MODE_DELETE;
			else if (pick < 80)
				req_mode = MODE_GET;
			else if (pick < 90)
				req_mode = MODE_PUSH;
			else
				req_mode = MODE_INSERT;
		end
		// positions mostly inside or just past the list, some across the full range
		if ($urandom_range(99) < 12)
			req_pos = POS_W'($urandom);
		else
			req_pos = POS_W'($urandom_range(0, DEPTH + 1));
		case ($urandom_range(9))
			0: req_val = {1'b1, {(DATA_W-1){1'b0}}};
			1: req_val = {1'b0, {(DATA_W-1){1'b1}}};
			2: req_val = '0;
			3: req_val = '1;
			default: req_val = DATA_W'($urandom);
		endcase
		send_request(req_mode, req_pos, req_val);
	endtask

	initial begin
		int p;
		int i;
		int idle_profile [3];
		idle_profile[0] = 28;
		idle_profile[1] = 50;
		idle_profile[2] = 0;
		arst_n = 1'b0;
		start = 1'b0;
		mode = MODE_PUSH;
		position = '0;
		item_value = '0;
		sent_count = 0;
		sender_idle_pct = 0;
		fill_bias = 1'b0;
		bias_left = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: refusals on the empty list come first, since the head can never
		// be deleted and the list never returns to empty after the first push
		sender_idle_pct = 0;
		send_request(MODE_GET, 8'd0, 32'sd0);
		send_request(MODE_DELETE, 8'd0, 32'sd0);
		send_request(MODE_DELETE, 8'd3, 32'sd0);
		send_request(MODE_INSERT, 8'd1, 32'sd5);
		// value extremes
		send_request(MODE_PUSH, 8'hff, {1'b1, {(DATA_W-1){1'b0}}});
		send_request(MODE_PUSH, 8'd0, {1'b0, {(DATA_W-1){1'b1}}});
		send_request(MODE_PUSH, 8'd0, '1);
		send_request(MODE_PUSH, 8'd0, '0);
		// insert placement: in the middle, at zero and far past the end
		send_request(MODE_INSERT, 8'd1, 32'sd111);
		send_request(MODE_INSERT, 8'd0, 32'sd222);
		send_request(MODE_INSERT, 8'hff, 32'sd333);
		// reads, including one clamped to the last element
		send_request(MODE_GET, 8'd0, 32'sd0);
		send_request(MODE_GET, 8'd2, 32'sd0);
		send_request(MODE_GET, 8'hff, 32'sd0);
		// delete in the middle, past the end, at the head
		send_request(MODE_DELETE, 8'd1, 32'sd0);
		send_request(MODE_DELETE, 8'd200, 32'sd0);
		send_request(MODE_DELETE, 8'd0, 32'sd0);
		// top up to capacity, then a push and an insert must both be refused
		for (i = 0; i < 10; i++)
			send_request(MODE_PUSH, 8'd0, DATA_W'($urandom));
		send_request(MODE_PUSH, 8'd0, 32'sd7);
		send_request(MODE_INSERT, 8'd3, 32'sd9);
		send_request(MODE_GET, 8'd15, 32'sd0);
		send_request(MODE_DELETE, 8'd15, 32'sd0);

		// random traffic under three sender idle profiles
		for (p = 0; p < 3; p++) begin
			wait_for_quiet();
			sender_idle_pct = idle_profile[p];
			for (i = 0; i < RANDOM_PER_PHASE; i++)
				send_random_request();
		end

		// drain: last result, then a margin for anything stray
		wait_for_quiet();
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("%0d request transactions: directed refusals on empty and full lists,", sent_count);
		$display("then random fill and drain traffic with sender idle at 28, 50 and 0 percent");
		if (fail_count == 0 && pending_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
